// File: src/sha1md_pkg.sv
// sha1md_pkg: types, constants and round functions for the sha-1 message digest block
package sha1md_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    // round count of one compression
    localparam int ROUNDS = 80;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

    // digest words per message
    localparam int WORDS = 5;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORDS - 1);

    // block geometry in bytes
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;

    // padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // initial chaining words
    localparam logic [31:0] H_INIT [WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round boundaries
    localparam logic [ROUND_W-1:0] R20 = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] R40 = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] R60 = ROUND_W'(60);

    // boolean function of one round
    function automatic logic [31:0] round_f(input logic [ROUND_W-1:0] r,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (r < R20) begin
            f = (b & c) | (~b & d);
        end else if (r < R40) begin
            f = b ^ c ^ d;
        end else if (r < R60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    // additive constant of one round
    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] r);
        logic [31:0] k;
        if (r < R20) begin
            k = K0;
        end else if (r < R40) begin
            k = K1;
        end else if (r < R60) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

endpackage

// File: src/sha1_message_digest_top.sv
// sha1_message_digest_top: byte-serial sha-1 with one shared round unit and padding sequencer
// The 64th byte of a block starts a compression (80 rounds of the single round adder, then the
// chaining update) during which no byte is accepted.
// An end transfer runs the padding one byte per cycle (rest of the block, plus a second block of
// 64 when the marker leaves no room for the length: up to 72 bytes), with one or two
// compressions, then offers the five digest words, one per output transfer.
// Reset (rst_n low, asynchronous) clears the sequencer, fill count and bit count and loads the
// initial chaining words; the schedule window, byte assembly and working registers hold no
// reset value.
module sha1_message_digest_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam int RW = sha1md_pkg::ROUND_W;
    localparam int IW = sha1md_pkg::IDX_W;

    sha1md_pkg::state_t state_reg, state_next;

    logic [5:0]    fill_reg;
    logic [23:0]   word_reg;
    logic [31:0]   w_reg [16];
    logic [63:0]   msg_bits_reg;
    logic [63:0]   len_reg;
    logic          pad_first_reg;
    logic          len_ok_reg;
    logic          pad_active_reg;
    logic          finish_reg;
    logic [RW-1:0] round_reg;
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]   h_reg [sha1md_pkg::WORDS];
    logic [IW-1:0] idx_reg;

    logic          in_xfer;
    logic          out_xfer;
    logic          out_done;
    logic          in_last;
    logic          push_en;
    logic [7:0]    push_byte;
    logic [7:0]    pad_byte;
    logic          pad_len;
    logic          block_full;
    logic [31:0]   w_new;
    logic [31:0]   t_sum;

    // handshakes
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign out_done = out_xfer && (idx_reg == sha1md_pkg::IDX_LAST);
    assign in_last  = in_xfer && s_axis_tlast;

    // padding byte source: marker, zeros, then the bit length big-endian
    assign pad_len = !pad_first_reg && len_ok_reg && (fill_reg >= sha1md_pkg::FILL_LEN);
    always_comb
    begin
        if (pad_first_reg) begin
            pad_byte = sha1md_pkg::PAD_BYTE;
        end else if (pad_len) begin
            pad_byte = len_reg[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // byte path shared by message and padding
    assign push_en    = (in_xfer && s_axis_tuser[0]) || (state_reg == sha1md_pkg::ST_PAD);
    assign push_byte  = (state_reg == sha1md_pkg::ST_PAD) ? pad_byte : s_axis_tdata;
    assign block_full = push_en && (fill_reg == sha1md_pkg::FILL_LAST);

    // schedule expansion and round sum
    assign w_new = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                    w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign t_sum = {a_reg[26:0], a_reg[31:27]}
                 + sha1md_pkg::round_f(round_reg, b_reg, c_reg, d_reg)
                 + e_reg + w_reg[0] + sha1md_pkg::round_k(round_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1md_pkg::ST_LOAD:
            begin
                if (in_xfer) begin
                    if (block_full) begin
                        state_next = sha1md_pkg::ST_ROUND;
                    end else if (s_axis_tlast) begin
                        state_next = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                if (block_full) begin
                    state_next = sha1md_pkg::ST_ROUND;
                end
            end
            sha1md_pkg::ST_ROUND:
            begin
                if (round_reg == sha1md_pkg::ROUND_LAST) begin
                    state_next = sha1md_pkg::ST_ADD;
                end
            end
            sha1md_pkg::ST_ADD:
            begin
                if (finish_reg) begin
                    state_next = sha1md_pkg::ST_OUT;
                end else if (pad_active_reg) begin
                    state_next = sha1md_pkg::ST_PAD;
                end else begin
                    state_next = sha1md_pkg::ST_LOAD;
                end
            end
            sha1md_pkg::ST_OUT:
            begin
                if (out_done) begin
                    state_next = sha1md_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sha1md_pkg::ST_LOAD;
            end
        endcase
    end

    // port outputs
    always_comb
    begin
        s_axis_tready = (state_reg == sha1md_pkg::ST_LOAD);
        m_axis_tvalid = (state_reg == sha1md_pkg::ST_OUT);
        m_axis_tdata  = h_reg[idx_reg];
        m_axis_tuser  = idx_reg;
        m_axis_tlast  = (idx_reg == sha1md_pkg::IDX_LAST);
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= sha1md_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // fill count, bit count and padding control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg       <= '0;
            msg_bits_reg   <= '0;
            len_reg        <= '0;
            pad_first_reg  <= 1'b0;
            len_ok_reg     <= 1'b0;
            pad_active_reg <= 1'b0;
            finish_reg     <= 1'b0;
        end else begin
            if (push_en) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (out_done) begin
                msg_bits_reg <= '0;
            end else if (in_xfer && s_axis_tuser[0]) begin
                msg_bits_reg <= msg_bits_reg + 64'd8;
            end
            if (in_last) begin
                len_reg <= msg_bits_reg + (s_axis_tuser[0] ? 64'd8 : 64'd0);
            end else if ((state_reg == sha1md_pkg::ST_PAD) && pad_len) begin
                len_reg <= {len_reg[55:0], 8'h00};
            end
            if (in_last) begin
                pad_first_reg <= 1'b1;
            end else if (state_reg == sha1md_pkg::ST_PAD) begin
                pad_first_reg <= 1'b0;
            end
            // length may go in this block only if the marker left room for it
            if ((state_reg == sha1md_pkg::ST_PAD) && block_full) begin
                len_ok_reg <= 1'b1;
            end else if ((state_reg == sha1md_pkg::ST_PAD) && pad_first_reg) begin
                len_ok_reg <= (fill_reg < sha1md_pkg::FILL_LEN);
            end
            if (in_last) begin
                pad_active_reg <= 1'b1;
            end else if (out_done) begin
                pad_active_reg <= 1'b0;
            end
            if ((state_reg == sha1md_pkg::ST_PAD) && block_full && pad_len) begin
                finish_reg <= 1'b1;
            end else if (out_done) begin
                finish_reg <= 1'b0;
            end
        end
    end

    // byte assembly and schedule window
    always_ff @(posedge clk)
    begin
        if (push_en) begin
            word_reg <= {word_reg[15:0], push_byte};
        end
        if (push_en && (fill_reg[1:0] == 2'd3)) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= {word_reg, push_byte};
        end else if (state_reg == sha1md_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    // round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            round_reg <= '0;
        end else if (state_reg == sha1md_pkg::ST_ROUND) begin
            round_reg <= (round_reg == sha1md_pkg::ROUND_LAST) ? '0 : round_reg + RW'(1);
        end
    end

    // working variables of the round unit
    always_ff @(posedge clk)
    begin
        if (block_full) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (state_reg == sha1md_pkg::ST_ROUND) begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // chaining words and output word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < sha1md_pkg::WORDS; i++) begin
                h_reg[i] <= sha1md_pkg::H_INIT[i];
            end
            idx_reg <= '0;
        end else begin
            if (state_reg == sha1md_pkg::ST_ADD) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end else if (out_done) begin
                for (int i = 0; i < sha1md_pkg::WORDS; i++) begin
                    h_reg[i] <= sha1md_pkg::H_INIT[i];
                end
            end
            if (out_done) begin
                idx_reg <= '0;
            end else if (out_xfer) begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // input and output sides never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output open together");

    // a full block from the input always starts a compression
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && block_full) |=> (state_reg == sha1md_pkg::ST_ROUND))
        else $error("full block did not start compression");

    // digest is offered only after a chaining update
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == sha1md_pkg::ST_ADD))
        else $error("digest offered without compression");

    // word index stays within the digest
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (idx_reg <= sha1md_pkg::IDX_LAST))
        else $error("word index out of range");

    // round counter idles at zero outside compression
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha1md_pkg::ST_ROUND) |-> (round_reg == '0))
        else $error("round counter left running");

endmodule

// File: bench/sha1_message_digest_top_tb.sv
// sha1_message_digest_top_tb: self-checking bench for the byte-serial sha-1 digest block
module sha1_message_digest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run control
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 160;

    // sha-1 initial chaining words
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // round constants and padding marker
    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // one expected digest word
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] byte_valid
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_index
    logic        m_axis_tlast;           // last_word

    // bench state
    digest_word_t digest_q [$];
    digest_word_t want;
    int          mismatches = 0;
    int          idle_run = 0;
    int          ready_gap = 0;
    logic        no_idle = 1'b0;
    logic        hold_req = 1'b0;

    // predicted block state
    logic [7:0]  blk [64];
    int unsigned blk_fill;
    logic [63:0] bit_count;
    logic [31:0] chain [5];

    sha1_message_digest_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #5 clk = ~clk;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // one 80-round compression of the buffered block into the chaining words
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        end
        for (int r = 16; r < 80; r++) begin
            w[r] = rotl32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end else begin
                f = b ^ c ^ d;
                k = RK3;
            end
            t = rotl32(a, 5) + f + e + w[r] + k;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endfunction

    function automatic void restart_digest();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        chain[4] = IV4;
        blk_fill = 0;
        bit_count = 64'd0;
    endfunction

    // advance the predicted state by one accepted input transfer
    function automatic void absorb_item(input logic [7:0] data, input logic valid,
                                        input logic last_in);
        logic [63:0] total;
        digest_word_t entry;
        if (valid) begin
            blk[blk_fill] = data;
            blk_fill++;
            if (blk_fill == 64) begin
                compress_block();
                bit_count = bit_count + 64'd512;
                blk_fill = 0;
            end
        end
        if (last_in) begin
            total = bit_count + 64'(blk_fill * 8);
            blk[blk_fill] = PAD_MARK;
            for (int j = blk_fill + 1; j < 64; j++) begin
                blk[j] = 8'h00;
            end
            // no room for the length field: one extra block
            if (blk_fill >= 56) begin
                compress_block();
                for (int j = 0; j < 56; j++) begin
                    blk[j] = 8'h00;
                end
            end
            for (int j = 0; j < 8; j++) begin
                blk[56+j] = total[63-8*j -: 8];
            end
            compress_block();
            for (int i = 0; i < 5; i++) begin
                entry.word  = chain[i];
                entry.index = 3'(i);
                entry.last  = (i == 4);
                digest_q.push_back(entry);
            end
            restart_digest();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // one input transfer, called and returning at a falling edge with tvalid left high
    task automatic send_item(input logic [7:0] data, input logic valid, input logic last_in);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= valid;
        s_axis_tlast  <= last_in;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        absorb_item(data, valid, last_in);
        @(negedge clk);
    endtask

    // drop tvalid and wait until every predicted word has been received
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (digest_q.size() != 0);
    endtask

    // random-content message, ended either on its last byte or by a separate end transfer
    task automatic send_message(input int len, output int sent);
        logic tail;
        tail = (len > 0) && ($urandom_range(0, 1) == 1);
        sent = 0;
        for (int i = 0; i < len; i++) begin
            // occasional transfer that carries neither flag
            if ($urandom_range(0, 11) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
                sent++;
            end
            send_item(8'($urandom), 1'b1, tail && (i == len - 1));
            sent++;
        end
        if (!tail) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            sent++;
        end
    endtask

    // empty message, short messages, byte extremes, end with and without a byte
    task automatic test_edge_messages();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        wait_drained();
    endtask

    // receiver holds off long enough for the digest to back up into the input
    task automatic test_output_backpressure();
        int sent;
        hold_req = 1'b1;
        send_message(6, sent);
        send_message(3, sent);
        send_message(2, sent);
        wait_drained();
    endtask

    // block-boundary lengths first, then mostly short messages with some boundary ones
    task automatic test_random_messages();
        int forced [3];
        int bounds [4];
        int items;
        int len;
        int sent;
        int n;
        forced = '{55, 56, 64};
        bounds = '{55, 56, 63, 64};
        items = 0;
        n = 0;
        while (items < RANDOM_ITEMS) begin
            if (n < 3) begin
                len = forced[n];
            end else if ($urandom_range(0, 9) < 2) begin
                len = bounds[$urandom_range(0, 3)];
            end else begin
                len = $urandom_range(0, 9);
            end
            n++;
            send_message(len, sent);
            items += sent;
            // sometimes let the pipeline empty between messages
            if ($urandom_range(0, 4) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // messages back to back with neither side idling
    task automatic test_back_to_back();
        int sent;
        no_idle = 1'b1;
        for (int i = 0; i < 4; i++) begin
            send_message($urandom_range(1, 8), sent);
        end
        wait_drained();
    endtask

    // output receiver with random stalls and the long hold-off
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (ready_gap > 0) begin
            m_axis_tready <= 1'b0;
            ready_gap--;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            ready_gap = $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // check each output transfer against the oldest predicted word
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output transfer, word %h", m_axis_tdata));
            end else begin
                want = digest_q.pop_front();
                if (m_axis_tdata !== want.word) begin
                    report_mismatch($sformatf("word %0d: digest %h, expected %h",
                                              want.index, m_axis_tdata, want.word));
                end
                if (m_axis_tuser !== want.index) begin
                    report_mismatch($sformatf("word index %0d, expected %0d",
                                              m_axis_tuser, want.index));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("word %0d: last flag %b, expected %b",
                                              want.index, m_axis_tlast, want.last));
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // reset, test sequence and final verdict
    initial begin
        for (int j = 0; j < 64; j++) begin
            blk[j] = 8'h00;
        end
        restart_digest();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_edge_messages();
        test_output_backpressure();
        test_random_messages();
        test_back_to_back();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (digest_q.size() != 0) begin
            report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
